// ===== rtl/core/fsk_tone_generator_macros.svh =====
// assertion macros for the fsk tone generator
// used by the top level only, no other dependencies
`ifndef FSK_TONE_GENERATOR_MACROS_SVH
`define FSK_TONE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define FSKG_ASSERT(lbl, clock, resetn, prop) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (prop)) \
        else $error("fsk tone generator check failed");

// antecedent implies consequent on the next edge
`define FSKG_ASSERT_NEXT(lbl, clock, resetn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("fsk tone generator check failed");

`else

`define FSKG_ASSERT(lbl, clock, resetn, prop)
`define FSKG_ASSERT_NEXT(lbl, clock, resetn, ante, cons)

`endif

`endif

// ===== rtl/core/fskg_pkg.sv =====
// shared types and constants of the fsk tone generator
// no dependencies
`default_nettype none

package fskg_pkg;

    localparam int FSKG_PHASE_BITS = 32;
    localparam int FSKG_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int INC_BITS   = 32;
    localparam int SPS_BITS   = 13;
    localparam int COUNT_BITS = 12;
    localparam int SYM_BITS   = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [SPS_BITS-1:0] MAX_SPS = 13'd4096;

    // register indexes of the config port
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_INC = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TONE_INC = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPS      = 2'd2;

    localparam logic [INC_BITS-1:0] BASE_INC_RESET = 32'd503316480;
    localparam logic [INC_BITS-1:0] TONE_INC_RESET = 32'd2097152;
    localparam logic [SPS_BITS-1:0] SPS_RESET      = 13'd2048;

    typedef struct packed {
        logic [SYM_BITS-1:0] symbol;
        logic                start_req;
    } fskg_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          symbol_end;
    } fskg_out_t;

    // control travelling from the nco stage to the table stage
    typedef struct packed {
        logic valid;
        logic negate;
        logic last;
    } fskg_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/fskg_nco.sv =====
// phase accumulator, symbol counter and quarter-wave index fold
// depends on fskg_pkg
`default_nettype none

module fskg_nco #(
    parameter int PHASE_BITS = fskg_pkg::FSKG_PHASE_BITS,
    parameter int TABLE_BITS = fskg_pkg::FSKG_TABLE_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               word_valid,
    input  wire fskg_pkg::fskg_in_t                 word,
    output logic                                    word_ready,
    input  wire logic [fskg_pkg::INC_BITS-1:0]      base_increment,
    input  wire logic [fskg_pkg::INC_BITS-1:0]      tone_increment,
    input  wire logic [fskg_pkg::SPS_BITS-1:0]      samples_per_symbol,
    input  wire logic                               take,
    output fskg_pkg::fskg_ctl_t                     ctl,
    output logic [TABLE_BITS-2:0]                   q_index
);
    import fskg_pkg::*;

    localparam int PROD_BITS = INC_BITS + SYM_BITS;
    localparam int SUM_BITS  = (PHASE_BITS > PROD_BITS) ? PHASE_BITS : PROD_BITS;
    localparam int R_BITS    = TABLE_BITS - 1;
    localparam logic [R_BITS-1:0] QUARTER = R_BITS'(1) << (TABLE_BITS - 2);

    logic [PHASE_BITS-1:0] phase_reg, phase_next, phase_eff;
    logic [COUNT_BITS-1:0] count_reg, count_next, count_eff;
    logic [SYM_BITS-1:0]   held_reg, held_next;
    logic                  negate;
    logic                  last;
    logic [R_BITS-1:0]     qidx;

    logic [TABLE_BITS-1:0] idx;
    logic [R_BITS-1:0]     r;
    logic                  upper;
    logic [PROD_BITS-1:0]  tone_step;
    logic [SUM_BITS-1:0]   phase_sum;
    logic [SPS_BITS-1:0]   count_inc;
    logic                  step;

    assign word_ready = take;
    assign step       = word_valid && word_ready;

    always_comb
    begin
        phase_eff = word.start_req ? '0 : phase_reg;
        count_eff = word.start_req ? '0 : count_reg;
        held_next = (count_eff == '0) ? word.symbol : held_reg;

        idx   = phase_eff[PHASE_BITS-1 -: TABLE_BITS];
        r     = idx[R_BITS-1:0];
        upper = r > QUARTER;
        // second quarter of a half wave mirrors onto the first
        qidx   = upper ? (R_BITS'(0) - r) : r;
        negate = upper ^ idx[TABLE_BITS-1];

        count_inc = {1'b0, count_eff} + SPS_BITS'(1);
        last      = count_inc >= samples_per_symbol;
        count_next = last ? '0 : count_inc[COUNT_BITS-1:0];

        tone_step  = PROD_BITS'(held_next) * PROD_BITS'(tone_increment);
        phase_sum  = SUM_BITS'(phase_eff) + SUM_BITS'(base_increment)
                   + SUM_BITS'(tone_step);
        phase_next = phase_sum[PHASE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            count_reg  <= '0;
            held_reg   <= '0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                held_reg  <= held_next;
            end
        end
    end

    assign ctl.valid  = word_valid;
    assign ctl.negate = negate;
    assign ctl.last   = last;
    assign q_index    = qidx;

endmodule

`default_nettype wire

// ===== rtl/core/fskg_cos_lookup.sv =====
// quarter-wave cosine table and output word register
// depends on fskg_pkg
`default_nettype none

module fskg_cos_lookup #(
    parameter int TABLE_BITS = fskg_pkg::FSKG_TABLE_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire fskg_pkg::fskg_ctl_t    ctl,
    input  wire logic [TABLE_BITS-2:0]  q_index,
    output logic                        take,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output fskg_pkg::fskg_out_t         out_data
);
    import fskg_pkg::*;

    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam logic [63:0] QuarterW   = 64'(QUARTER);
    localparam logic [63:0] TwoQuarter = 64'(2 * QUARTER);
    localparam logic [63:0] PiQ30      = 64'd3373259426;
    localparam logic [63:0] OneQ30     = 64'd1 << 30;
    localparam logic [63:0] HalfQ30    = 64'd1 << 29;
    localparam logic [63:0] Amplitude  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef logic [SAMPLE_BITS-1:0] qtab_t [QUARTER+1];

    // taylor series to the x^16 term in q30, rounded to the output amplitude
    function automatic logic [SAMPLE_BITS-1:0] quarter_cos(input logic [63:0] m);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        scaled;
        x    = (PiQ30 * m + QuarterW) / TwoQuarter;
        x2   = (x * x + HalfQ30) >> 30;
        term = OneQ30;
        sum  = $signed(OneQ30);
        term = ((term * x2) >> 30) / 64'd2;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd12;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd30;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd56;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd90;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd132;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd182;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd240;
        sum  = sum + $signed(term);
        if (sum < 0)
            sum = '0;
        if (sum > $signed(OneQ30))
            sum = $signed(OneQ30);
        scaled = ($unsigned(sum) * Amplitude + HalfQ30) >> 30;
        return scaled[SAMPLE_BITS-1:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int m = 0; m <= QUARTER; m++)
            t[m] = quarter_cos(64'(m));
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    logic                          out_valid_reg, out_valid_next;
    fskg_out_t                     out_data_reg, out_data_next;
    logic [SAMPLE_BITS-1:0]        mag;

    assign take = !out_valid_reg || out_ready;

    always_comb
    begin
        mag = QTAB[q_index];
        out_data_next.sample     = ctl.negate ? $signed(-mag) : $signed(mag);
        out_data_next.symbol_end = ctl.last;
        out_valid_next = take ? ctl.valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && ctl.valid)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fsk_tone_generator.sv =====
// fsk tone generator top: input register, config registers, nco and cosine table
// a result word passes from the input word register to the output word register
// throughput: one word per cycle while out_ready allows, set by the combinational phase add and table read
// back-pressure stalls the input and output registers in place, no word is dropped
// reset clears phase, sample count, held symbol and restores the config defaults
`default_nettype none

`include "fsk_tone_generator_macros.svh"

module fsk_tone_generator #(
    parameter int PHASE_BITS = fskg_pkg::FSKG_PHASE_BITS,
    parameter int TABLE_BITS = fskg_pkg::FSKG_TABLE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire fskg_pkg::fskg_in_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output fskg_pkg::fskg_out_t                    out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fskg_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [fskg_pkg::INC_BITS-1:0]     cfg_data
);
    import fskg_pkg::*;

    logic [INC_BITS-1:0] base_inc_reg, base_inc_next;
    logic [INC_BITS-1:0] tone_inc_reg, tone_inc_next;
    logic [SPS_BITS-1:0] sps_reg, sps_next;
    logic [SPS_BITS-1:0] sps_clamped;

    logic                in_valid_reg, in_valid_next;
    fskg_in_t            in_word_reg;
    logic                s1_ready;
    fskg_ctl_t           ctl;
    logic [TABLE_BITS-2:0] q_index;
    logic                take;

    assign cfg_ready = 1'b1;

    // symbol length held already clamped to 1..4096
    always_comb
    begin
        sps_clamped = cfg_data[SPS_BITS-1:0];
        if (sps_clamped == '0)
            sps_clamped = SPS_BITS'(1);
        else if (sps_clamped > MAX_SPS)
            sps_clamped = MAX_SPS;

        base_inc_next = base_inc_reg;
        tone_inc_next = tone_inc_reg;
        sps_next      = sps_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BASE_INC: base_inc_next = cfg_data;
                CFG_TONE_INC: tone_inc_next = cfg_data;
                CFG_SPS:      sps_next      = sps_clamped;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_inc_reg <= BASE_INC_RESET;
            tone_inc_reg <= TONE_INC_RESET;
            sps_reg      <= SPS_RESET;
        end
        else
        begin
            base_inc_reg <= base_inc_next;
            tone_inc_reg <= tone_inc_next;
            sps_reg      <= sps_next;
        end
    end

    // input word register
    assign in_ready      = !in_valid_reg || s1_ready;
    assign in_valid_next = in_ready ? in_valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_word_reg <= in_data;
    end

    fskg_nco #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_nco (
        .clk                (clk),
        .rst_n              (rst_n),
        .word_valid         (in_valid_reg),
        .word               (in_word_reg),
        .word_ready         (s1_ready),
        .base_increment     (base_inc_reg),
        .tone_increment     (tone_inc_reg),
        .samples_per_symbol (sps_reg),
        .take               (take),
        .ctl                (ctl),
        .q_index            (q_index)
    );

    fskg_cos_lookup #(
        .TABLE_BITS (TABLE_BITS)
    ) u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .q_index   (q_index),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `FSKG_ASSERT(a_sps_range, clk, rst_n, (sps_reg != '0) && (sps_reg <= MAX_SPS))
    `FSKG_ASSERT_NEXT(a_stage2_hold, clk, rst_n, ctl.valid && !take, ctl.valid)
    `FSKG_ASSERT(a_no_overrun, clk, rst_n,
                 !(out_valid && !out_ready && ctl.valid) || (in_ready == !in_valid_reg))

endmodule

`default_nettype wire
